/* rtl/orl_pkg.sv */
`timescale 1ns / 1ps
package orl_pkg;

  localparam int unsigned DefCapacity = 128;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_SEARCH = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_BADPOS = 3'd2,
    ST_EMPTY  = 3'd3,
    ST_MISS   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    OP_HOLD   = 3'd0,
    OP_APPEND = 3'd1,
    OP_INSERT = 3'd2,
    OP_DELETE = 3'd3,
    OP_SEARCH = 3'd4
  } op_e;

  typedef struct packed {
    logic signed [31:0] id;
    logic [63:0]        name_lo;
    logic [15:0]        name_hi;
    logic [7:0]         age;
  } rec_t;

  typedef struct packed {
    logic hit;
    rec_t rec;
  } found_t;

endpackage

/* rtl/orl_cell.sv */
`timescale 1ns / 1ps
module orl_cell import orl_pkg::*; #(
  parameter int unsigned CAPACITY = DefCapacity,
  parameter int unsigned INDEX    = 0,
  localparam int unsigned CntW    = $clog2(CAPACITY + 1)
) (
  input  logic            clk_i,
  input  op_e             op_i,
  input  logic [CntW-1:0] idx_i,
  input  logic [CntW-1:0] len_i,
  input  rec_t            wr_rec_i,
  input  rec_t            prev_rec_i,
  input  rec_t            next_rec_i,
  input  found_t          carry_i,
  output rec_t            rec_o,
  output found_t          carry_o
);

  localparam logic [CntW-1:0] MyIdx = CntW'(INDEX);

  rec_t   rec_q, rec_d;
  found_t carry_q, carry_d;
  logic   match;

  assign match = (MyIdx < len_i) && (rec_q.name_lo == wr_rec_i.name_lo)
                 && (rec_q.name_hi == wr_rec_i.name_hi);

  always_comb begin
    rec_d   = rec_q;
    carry_d = carry_q;
    unique case (op_i)
      OP_APPEND: begin
        if (MyIdx == idx_i) rec_d = wr_rec_i;
      end
      OP_INSERT: begin
        if (MyIdx == idx_i) begin
          rec_d = wr_rec_i;
        end else if (MyIdx > idx_i) begin
          rec_d = prev_rec_i;
        end
      end
      OP_DELETE: begin
        if (MyIdx >= idx_i) rec_d = next_rec_i;
      end
      OP_SEARCH: begin
        if (match) begin
          carry_d.hit = 1'b1;
          carry_d.rec = rec_q;
        end else begin
          carry_d = carry_i;
        end
      end
      default: begin
        rec_d = rec_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    rec_q   <= rec_d;
    carry_q <= carry_d;
  end

  assign rec_o   = rec_q;
  assign carry_o = carry_q;

endmodule

/* rtl/orl_ctrl.sv */
`timescale 1ns / 1ps
module orl_ctrl import orl_pkg::*; #(
  parameter int unsigned CAPACITY = DefCapacity,
  localparam int unsigned CntW    = $clog2(CAPACITY + 1),
  localparam int unsigned CmpW    = (CntW > 8) ? CntW : 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      cmd_i,
  input  logic [7:0]      position_i,
  input  rec_t            in_rec_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [2:0]      status_o,
  output logic [7:0]      entry_count_o,
  input  logic            hit_i,
  output logic            load_o,
  output logic            load_hit_o,
  output op_e             op_o,
  output logic [CntW-1:0] idx_o,
  output logic [CntW-1:0] len_o,
  output rec_t            wr_rec_o
);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_SEARCH = 2'b10
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] len_q, len_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  status_e         status_q, status_d;
  logic [CntW-1:0] count_q, count_d;
  rec_t            key_q;
  logic            out_free, accept, full, pos_ok, done;
  logic [CmpW-1:0] pos_w, len_w, count_w;
  cmd_e            cmd;

  assign cmd      = cmd_e'(cmd_i);
  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign accept   = in_valid_i && in_ready_o;
  assign full     = (len_q == CntW'(CAPACITY));
  assign pos_w    = CmpW'(position_i);
  assign len_w    = CmpW'(len_q);
  assign pos_ok   = (pos_w != '0) && (pos_w <= len_w);
  assign done     = (cnt_q == CntW'(CAPACITY));

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    count_d     = count_q;
    op_o        = OP_HOLD;
    idx_o       = CntW'(position_i) - CntW'(1);
    wr_rec_o    = in_rec_i;
    load_o      = 1'b0;
    load_hit_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          load_o      = 1'b1;
          out_valid_d = 1'b1;
          status_d    = ST_OK;
          unique case (cmd)
            CMD_APPEND: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                op_o  = OP_APPEND;
                idx_o = len_q;
                len_d = len_q + CntW'(1);
              end
            end
            CMD_INSERT: begin
              priority if (full) begin
                status_d = ST_FULL;
              end else if (!pos_ok) begin
                status_d = ST_BADPOS;
              end else begin
                op_o  = OP_INSERT;
                len_d = len_q + CntW'(1);
              end
            end
            CMD_DELETE: begin
              if (!pos_ok) begin
                status_d = ST_BADPOS;
              end else begin
                op_o  = OP_DELETE;
                len_d = len_q - CntW'(1);
              end
            end
            CMD_SEARCH: begin
              if (len_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                load_o      = 1'b0;
                out_valid_d = out_valid_q && !out_ready_i;
                status_d    = status_q;
                cnt_d       = '0;
                state_d     = S_SEARCH;
              end
            end
            default: status_d = ST_OK;
          endcase
          if (load_o) count_d = len_d;
        end
      end
      S_SEARCH: begin
        op_o     = OP_SEARCH;
        wr_rec_o = key_q;
        if (!done) begin
          cnt_d = cnt_q + CntW'(1);
        end else if (out_free) begin
          load_o      = 1'b1;
          load_hit_o  = 1'b1;
          out_valid_d = 1'b1;
          status_d    = hit_i ? ST_OK : ST_MISS;
          count_d     = len_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    count_q  <= count_d;
    if (accept) key_q <= in_rec_i;
  end

  assign count_w       = CmpW'(count_q);
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign entry_count_o = count_w[7:0];
  assign len_o         = len_q;

endmodule

/* rtl/ordered_record_list_unit.sv */
`timescale 1ns / 1ps
// Append, insert and delete act at the accepting edge: the cells of the chain that change shift or load in
// that same edge, and the result word is registered at the accepting edge.
// Search lets a match ripple from the tail cell to the head cell through the carry registers
// before the result is registered; one command is worked on at a time.
// Reset clears the record count and the handshake state; record contents are not reset.
module ordered_record_list_unit import orl_pkg::*; #(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         cmd_i,
  input  logic [7:0]         position_i,
  input  logic signed [31:0] entry_id_i,
  input  logic [63:0]        name_low_i,
  input  logic [15:0]        name_high_i,
  input  logic [7:0]         entry_age_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         status_o,
  output logic [7:0]         entry_count_o,
  output logic signed [31:0] found_id_o,
  output logic [63:0]        found_name_low_o,
  output logic [15:0]        found_name_high_o,
  output logic [7:0]         found_age_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  rec_t            in_rec, wr_rec, found_q;
  rec_t            recs [CAPACITY];
  found_t          carries [CAPACITY];
  op_e             op;
  logic [CntW-1:0] idx, len;
  logic            load, load_hit;

  assign in_rec.id      = entry_id_i;
  assign in_rec.name_lo = name_low_i;
  assign in_rec.name_hi = name_high_i;
  assign in_rec.age     = entry_age_i;

  orl_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .position_i   (position_i),
    .in_rec_i     (in_rec),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .entry_count_o(entry_count_o),
    .hit_i        (carries[0].hit),
    .load_o       (load),
    .load_hit_o   (load_hit),
    .op_o         (op),
    .idx_o        (idx),
    .len_o        (len),
    .wr_rec_o     (wr_rec)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    rec_t   prev_rec, next_rec;
    found_t carry_in;
    if (i == 0) begin : g_head
      assign prev_rec = '0;
    end else begin : g_body
      assign prev_rec = recs[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign next_rec = '0;
      assign carry_in = '0;
    end else begin : g_link
      assign next_rec = recs[i+1];
      assign carry_in = carries[i+1];
    end
    orl_cell #(
      .CAPACITY(CAPACITY),
      .INDEX   (i)
    ) u_cell (
      .clk_i     (clk_i),
      .op_i      (op),
      .idx_i     (idx),
      .len_i     (len),
      .wr_rec_i  (wr_rec),
      .prev_rec_i(prev_rec),
      .next_rec_i(next_rec),
      .carry_i   (carry_in),
      .rec_o     (recs[i]),
      .carry_o   (carries[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      found_q <= (load_hit && carries[0].hit) ? carries[0].rec : '0;
    end
  end

  assign found_id_o        = found_q.id;
  assign found_name_low_o  = found_q.name_lo;
  assign found_name_high_o = found_q.name_hi;
  assign found_age_o       = found_q.age;

endmodule
